/* src/gmdfs_pkg.sv */
// Package for the grid maze depth-first path finder.
// Holds the sizing constants, codes, payload and request types and the move table.
// No dependencies; every other file of the block refers to it by scoped names.
package gmdfs_pkg;

    // Grid geometry and the widths that follow from it.
    localparam int MAX_SIDE = 64;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int DEPTH_W  = ADDR_W + 1;
    localparam int SIDE_W   = COORD_W + 1;

    // Neighbour scan: eight directions plus one code for "all tried".
    localparam int NUM_DIRS = 8;
    localparam int DIR_W    = $clog2(NUM_DIRS);
    localparam int K_W      = DIR_W + 1;

    // Command codes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd4;

    // Reset value of the side length register.
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

    // Clockwise from east, rows growing southwards, two-bit signed offsets.
    localparam logic [1:0] MOVE_DR [NUM_DIRS] =
        '{2'b00, 2'b01, 2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b11};
    localparam logic [1:0] MOVE_DC [NUM_DIRS] =
        '{2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b11, 2'b00, 2'b01};

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               cell_blocked;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic               result_kind;
        logic               found;
        logic [DEPTH_W-1:0] path_length;
        logic [COORD_W-1:0] path_row;
        logic [COORD_W-1:0] path_col;
        logic               last_entry;
    } t_out_item;

    // Configuration register contents.
    typedef struct packed {
        logic [SIDE_W-1:0]  side_length;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } t_cfg;

    // Access request to the grid memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_grid_req;

    // Access request to the path stack memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_stack_req;

endpackage

/* src/gmdfs_grid_ram.sv */
// Grid cell store: one bit per cell, blocked or open, one write and one read port.
// Read data is registered and appears in the cycle after the read request.
// Depends on gmdfs_pkg for sizes and the request type.
module gmdfs_grid_ram (
    input  logic                 i_clk,
    input  gmdfs_pkg::t_grid_req i_req,
    output logic                 o_rdata
);

    logic r_mem [gmdfs_pkg::CELLS];
    logic r_rdata;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gmdfs_stack_ram.sv */
// Path stack store: one packed cell address per entry, one write and one read port.
// Read data is registered and held until the next read request.
// Depends on gmdfs_pkg for sizes and the request type.
module gmdfs_stack_ram (
    input  logic                              i_clk,
    input  gmdfs_pkg::t_stack_req             i_req,
    output logic [gmdfs_pkg::ADDR_W-1:0]      o_rdata
);

    logic [gmdfs_pkg::ADDR_W-1:0] r_mem [gmdfs_pkg::CELLS];
    logic [gmdfs_pkg::ADDR_W-1:0] r_rdata;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gmdfs_ctrl.sv */
// Sequencer of the path finder: command decode, depth-first search and result stage.
// Drives the grid and stack memories through request structs.
// Depends on gmdfs_pkg for types, codes and the move table.
module gmdfs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gmdfs_pkg::t_cfg              i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  gmdfs_pkg::t_in_item          i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output gmdfs_pkg::t_out_item         o_out_data,
    output gmdfs_pkg::t_grid_req         o_grid_req,
    input  logic                         i_grid_rdata,
    output gmdfs_pkg::t_stack_req        o_stack_req,
    input  logic [gmdfs_pkg::ADDR_W-1:0] i_stack_rdata
);

    localparam int CW = gmdfs_pkg::COORD_W;
    localparam int AW = gmdfs_pkg::ADDR_W;
    localparam int DW = gmdfs_pkg::DEPTH_W;
    localparam int SW = gmdfs_pkg::SIDE_W;
    localparam int KW = gmdfs_pkg::K_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [KW-1:0] K_ALL_TRIED = KW'(gmdfs_pkg::NUM_DIRS);
    localparam logic [DW-1:0] DEPTH_ONE   = DW'(1);
    localparam logic [DW-1:0] DEPTH_TWO   = DW'(2);

    // Control state.
    logic [1:0]    r_state, n_state;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_found, n_found;
    logic [KW-1:0] r_k, n_k;
    logic          r_pv, n_pv;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;

    // Payload state.
    logic [CW-1:0] r_top_row, n_top_row;
    logic [CW-1:0] r_top_col, n_top_col;
    logic [CW-1:0] r_pr, n_pr;
    logic [CW-1:0] r_pc, n_pc;
    logic          r_pend_found, n_pend_found;
    logic [DW-1:0] r_pend_len, n_pend_len;
    logic          r_pend_last, n_pend_last;
    gmdfs_pkg::t_out_item r_out, n_out;

    logic          in_acc;
    logic          out_free;
    logic [SW-1:0] eff_n;
    logic          ends_in_grid;
    logic [CW:0]   nb_row;
    logic [CW:0]   nb_col;
    logic          nb_in_grid;
    logic [gmdfs_pkg::DIR_W-1:0] dir;

    // Handshake on both channels.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || (r_pend && !out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Side length in use, clamped to the legal range.
    always_comb begin
        if (i_cfg.side_length == '0) begin
            eff_n = SW'(1);
        end else if (i_cfg.side_length > SW'(gmdfs_pkg::MAX_SIDE)) begin
            eff_n = SW'(gmdfs_pkg::MAX_SIDE);
        end else begin
            eff_n = i_cfg.side_length;
        end
    end

    assign ends_in_grid = ({1'b0, i_cfg.start_row} < eff_n) &&
                          ({1'b0, i_cfg.start_col} < eff_n) &&
                          ({1'b0, i_cfg.goal_row}  < eff_n) &&
                          ({1'b0, i_cfg.goal_col}  < eff_n);

    // Neighbour under test; an offset below zero wraps high and fails the bound check.
    assign dir    = r_k[gmdfs_pkg::DIR_W-1:0];
    assign nb_row = {1'b0, r_top_row} +
                    {{(CW-1){gmdfs_pkg::MOVE_DR[dir][1]}}, gmdfs_pkg::MOVE_DR[dir]};
    assign nb_col = {1'b0, r_top_col} +
                    {{(CW-1){gmdfs_pkg::MOVE_DC[dir][1]}}, gmdfs_pkg::MOVE_DC[dir]};
    assign nb_in_grid = (nb_row < eff_n) && (nb_col < eff_n);

    // Next-state logic: commands, search steps and the result stage.
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_found      = r_found;
        n_k          = r_k;
        n_pv         = r_pv;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_top_row    = r_top_row;
        n_top_col    = r_top_col;
        n_pr         = r_pr;
        n_pc         = r_pc;
        n_pend_found = r_pend_found;
        n_pend_len   = r_pend_len;
        n_pend_last  = r_pend_last;
        n_out        = r_out;
        o_grid_req   = '0;
        o_stack_req  = '0;

        // A taken result frees the output register.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // A popped path entry moves on once its stack data has arrived.
        if (r_pend && out_free) begin
            n_pend                = 1'b0;
            n_out_valid           = 1'b1;
            n_out.result_kind     = gmdfs_pkg::KIND_ENTRY;
            n_out.found           = r_pend_found;
            n_out.path_length     = r_pend_len;
            n_out.path_row        = r_pend_found ? i_stack_rdata[AW-1:CW] : '0;
            n_out.path_col        = r_pend_found ? i_stack_rdata[CW-1:0]  : '0;
            n_out.last_entry      = r_pend_last;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.opcode)
                        gmdfs_pkg::OP_LOAD: begin
                            o_grid_req.we    = 1'b1;
                            o_grid_req.waddr = {i_in_data.cell_row, i_in_data.cell_col};
                            o_grid_req.wdata = i_in_data.cell_blocked;
                        end
                        gmdfs_pkg::OP_SOLVE: begin
                            n_found = 1'b0;
                            n_k     = '0;
                            n_pv    = 1'b0;
                            if (!ends_in_grid) begin
                                n_depth = '0;
                                n_state = ST_DONE;
                            end else begin
                                // The entry cell is marked visited and pushed first.
                                o_grid_req.we     = 1'b1;
                                o_grid_req.waddr  = {i_cfg.start_row, i_cfg.start_col};
                                o_grid_req.wdata  = 1'b1;
                                o_stack_req.we    = 1'b1;
                                o_stack_req.waddr = '0;
                                o_stack_req.wdata = {i_cfg.start_row, i_cfg.start_col};
                                n_depth   = DEPTH_ONE;
                                n_top_row = i_cfg.start_row;
                                n_top_col = i_cfg.start_col;
                                if (i_cfg.start_row == i_cfg.goal_row &&
                                    i_cfg.start_col == i_cfg.goal_col) begin
                                    n_found = 1'b1;
                                    n_state = ST_DONE;
                                end else begin
                                    n_state = ST_SCAN;
                                end
                            end
                        end
                        gmdfs_pkg::OP_READ: begin
                            n_pend = 1'b1;
                            if (r_depth != '0) begin
                                o_stack_req.re    = 1'b1;
                                o_stack_req.raddr = AW'(r_depth - DEPTH_ONE);
                                n_depth      = r_depth - DEPTH_ONE;
                                n_pend_found = 1'b1;
                                n_pend_len   = r_depth - DEPTH_ONE;
                                n_pend_last  = (r_depth == DEPTH_ONE);
                            end else begin
                                n_pend_found = 1'b0;
                                n_pend_len   = '0;
                                n_pend_last  = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_pv && !i_grid_rdata) begin
                    // Open neighbour: mark it, push it and make it the new top.
                    o_grid_req.we     = 1'b1;
                    o_grid_req.waddr  = {r_pr, r_pc};
                    o_grid_req.wdata  = 1'b1;
                    o_stack_req.we    = 1'b1;
                    o_stack_req.waddr = r_depth[AW-1:0];
                    o_stack_req.wdata = {r_pr, r_pc};
                    n_depth   = r_depth + DEPTH_ONE;
                    n_top_row = r_pr;
                    n_top_col = r_pc;
                    n_k       = '0;
                    n_pv      = 1'b0;
                    if (r_pr == i_cfg.goal_row && r_pc == i_cfg.goal_col) begin
                        n_found = 1'b1;
                        n_state = ST_DONE;
                    end
                end else if (r_k == K_ALL_TRIED) begin
                    // Dead end: drop the top and fetch the one below it, or finish if the stack is now empty.
                    n_depth = r_depth - DEPTH_ONE;
                    n_pv    = 1'b0;
                    if (r_depth == DEPTH_ONE) begin
                        n_state = ST_DONE;
                    end else begin
                        o_stack_req.re    = 1'b1;
                        o_stack_req.raddr = AW'(r_depth - DEPTH_TWO);
                        n_state = ST_POP;
                    end
                end else begin
                    // Probe the next direction; its grid bit is checked next cycle.
                    o_grid_req.re    = nb_in_grid;
                    o_grid_req.raddr = {nb_row[CW-1:0], nb_col[CW-1:0]};
                    n_pv = nb_in_grid;
                    n_pr = nb_row[CW-1:0];
                    n_pc = nb_col[CW-1:0];
                    n_k  = r_k + KW'(1);
                end
            end
            ST_POP: begin
                n_top_row = i_stack_rdata[AW-1:CW];
                n_top_col = i_stack_rdata[CW-1:0];
                n_k       = '0;
                n_pv      = 1'b0;
                n_state   = ST_SCAN;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = gmdfs_pkg::KIND_STATUS;
                    n_out.found       = r_found;
                    n_out.path_length = r_found ? r_depth : '0;
                    n_out.path_row    = '0;
                    n_out.path_col    = '0;
                    n_out.last_entry  = 1'b0;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_found     <= 1'b0;
            r_k         <= '0;
            r_pv        <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_found     <= n_found;
            r_k         <= n_k;
            r_pv        <= n_pv;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top_row    <= n_top_row;
        r_top_col    <= n_top_col;
        r_pr         <= n_pr;
        r_pc         <= n_pc;
        r_pend_found <= n_pend_found;
        r_pend_len   <= n_pend_len;
        r_pend_last  <= n_pend_last;
        r_out        <= n_out;
    end

endmodule

/* src/grid_maze_dfs_path_finder_core.sv */
// A load gives no result; a read's stack data is registered first and its result then
// enters the output register, with one read accepted per cycle while the result channel
// is not stalled. A solve occupies the block until its status result is registered, its
// pace set by the single grid read port probing one neighbour per cycle.
// Reset is synchronous, active low: control and configuration return to their reset values;
// the grid and stack memories are not cleared; the stack needs no clearing pass.
module grid_maze_dfs_path_finder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gmdfs_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gmdfs_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gmdfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gmdfs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = gmdfs_pkg::COORD_W;
    localparam int SW = gmdfs_pkg::SIDE_W;

    gmdfs_pkg::t_cfg       r_cfg;
    gmdfs_pkg::t_grid_req  grid_req;
    gmdfs_pkg::t_stack_req stack_req;
    logic                  grid_rdata;
    logic [gmdfs_pkg::ADDR_W-1:0] stack_rdata;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.side_length <= gmdfs_pkg::SIDE_RESET;
            r_cfg.start_row   <= '0;
            r_cfg.start_col   <= '0;
            r_cfg.goal_row    <= '0;
            r_cfg.goal_col    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gmdfs_pkg::CFG_SIDE:      r_cfg.side_length <= i_cfg_data[SW-1:0];
                gmdfs_pkg::CFG_START_ROW: r_cfg.start_row   <= i_cfg_data[CW-1:0];
                gmdfs_pkg::CFG_START_COL: r_cfg.start_col   <= i_cfg_data[CW-1:0];
                gmdfs_pkg::CFG_GOAL_ROW:  r_cfg.goal_row    <= i_cfg_data[CW-1:0];
                gmdfs_pkg::CFG_GOAL_COL:  r_cfg.goal_col    <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Search sequencer and result stage.
    gmdfs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .o_grid_req    (grid_req),
        .i_grid_rdata  (grid_rdata),
        .o_stack_req   (stack_req),
        .i_stack_rdata (stack_rdata)
    );

    // Grid cell memory.
    gmdfs_grid_ram u_grid (
        .i_clk   (i_clk),
        .i_req   (grid_req),
        .o_rdata (grid_rdata)
    );

    // Path stack memory.
    gmdfs_stack_ram u_stack (
        .i_clk   (i_clk),
        .i_req   (stack_req),
        .o_rdata (stack_rdata)
    );

endmodule

/* src/gmdfs_checker.sv */
// Port-level checks on the result channel of the path finder.
// Depends on gmdfs_pkg for the result type and codes; bound to the top level below.
module gmdfs_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  gmdfs_pkg::t_out_item o_out_data
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result transaction keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // The start cell closes the path and leaves the stack empty.
    a_last_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == gmdfs_pkg::KIND_ENTRY &&
        o_out_data.last_entry |-> o_out_data.found && o_out_data.path_length == '0)
        else $error("last path entry inconsistent");

    // A failed search reports no path length and is not marked as a last entry.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == gmdfs_pkg::KIND_STATUS &&
        !o_out_data.found |-> o_out_data.path_length == '0 && !o_out_data.last_entry)
        else $error("failed search carries a path");

endmodule

bind grid_maze_dfs_path_finder_core gmdfs_checker u_gmdfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
